@@ src/pid_position_to_pwm_assert.svh @@
// assertion macros for the position controller
`ifndef PID_POSITION_TO_PWM_ASSERT_SVH
`define PID_POSITION_TO_PWM_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, idle in reset
`define PIDPWM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pidpwm: same-cycle check failed");

// next-cycle implication, sampled on the rising edge, idle in reset
`define PIDPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pidpwm: next-cycle check failed");

`endif

@@ src/pidpwm_pkg.sv @@
// shared types, constants and microcode program of the position controller
package pidpwm_pkg;

	localparam int PC_W  = 5;
	localparam int ACC_W = 69;
	localparam int MAG_W = 68;

	localparam logic signed [32:0] DEADBAND      = 33'sd50;
	localparam logic signed [33:0] SUM_LIMIT     = 34'sd5000000;
	localparam logic [23:0]        RECIP_100     = 24'd10737419;
	localparam int                 RECIP_SHIFT   = 30;
	localparam logic [15:0]        CMP_MAX       = 16'hFFFF;

	// register indexes
	localparam logic [2:0] REG_TARGET = 3'd0;
	localparam logic [2:0] REG_GAIN_P = 3'd1;
	localparam logic [2:0] REG_GAIN_I = 3'd2;
	localparam logic [2:0] REG_GAIN_D = 3'd3;
	localparam logic [2:0] REG_FLOOR  = 3'd4;
	localparam logic [2:0] REG_CEIL   = 3'd5;
	localparam logic [2:0] REG_PERIOD = 3'd6;

	// datapath operations
	localparam logic [3:0] OP_WAIT  = 4'd0;
	localparam logic [3:0] OP_ERR   = 4'd1;
	localparam logic [3:0] OP_BAND  = 4'd2;
	localparam logic [3:0] OP_MUL   = 4'd3;
	localparam logic [3:0] OP_ACC   = 4'd4;
	localparam logic [3:0] OP_ABS   = 4'd5;
	localparam logic [3:0] OP_DUTY  = 4'd6;
	localparam logic [3:0] OP_CMUL  = 4'd7;
	localparam logic [3:0] OP_RMUL  = 4'd8;
	localparam logic [3:0] OP_SCALE = 4'd9;
	localparam logic [3:0] OP_CLR   = 4'd10;
	localparam logic [3:0] OP_WR    = 4'd11;

	// jump conditions
	localparam logic [2:0] J_NEXT = 3'd0;
	localparam logic [2:0] J_IN   = 3'd1;
	localparam logic [2:0] J_ACT  = 3'd2;
	localparam logic [2:0] J_BAND = 3'd3;
	localparam logic [2:0] J_GOTO = 3'd4;
	localparam logic [2:0] J_OUT  = 3'd5;

	// multiplier gain and operand selects
	localparam logic [1:0] G_P = 2'd0;
	localparam logic [1:0] G_I = 2'd1;
	localparam logic [1:0] G_D = 2'd2;
	localparam logic [1:0] O_E = 2'd0;
	localparam logic [1:0] O_S = 2'd1;
	localparam logic [1:0] O_D = 2'd2;

	// program addresses
	localparam logic [PC_W-1:0] PC_WAIT = 5'd0;
	localparam logic [PC_W-1:0] PC_WR   = 5'd15;
	localparam logic [PC_W-1:0] PC_CLR  = 5'd16;

	typedef struct packed {
		logic [3:0]      op;
		logic [1:0]      gsel;
		logic [1:0]      osel;
		logic            hi;
		logic            acc_en;
		logic            acc_hi;
		logic [2:0]      jcond;
		logic [PC_W-1:0] jtgt;
	} uword_t;

	typedef struct packed {
		logic action;
		logic band;
	} dp_stat_t;

	typedef struct packed {
		logic signed [31:0] target;
		logic [31:0]        gain_p;
		logic [31:0]        gain_i;
		logic [31:0]        gain_d;
		logic [6:0]         floor_pct;
		logic [6:0]         ceil_pct;
		logic [15:0]        period;
	} cfg_t;

	function automatic uword_t uw_mk(input logic [3:0] op, input logic [1:0] gsel,
			input logic [1:0] osel, input logic hi, input logic acc_en,
			input logic acc_hi, input logic [2:0] jcond, input logic [PC_W-1:0] jtgt);
		uword_t w;
		w.op     = op;
		w.gsel   = gsel;
		w.osel   = osel;
		w.hi     = hi;
		w.acc_en = acc_en;
		w.acc_hi = acc_hi;
		w.jcond  = jcond;
		w.jtgt   = jtgt;
		return w;
	endfunction

	// control store
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			5'd0:  w = uw_mk(OP_WAIT,  G_P, O_E, 1'b0, 1'b0, 1'b0, J_IN,   PC_WAIT);
			5'd1:  w = uw_mk(OP_ERR,   G_P, O_E, 1'b0, 1'b0, 1'b0, J_ACT,  PC_CLR);
			5'd2:  w = uw_mk(OP_BAND,  G_P, O_E, 1'b0, 1'b0, 1'b0, J_BAND, PC_WR);
			5'd3:  w = uw_mk(OP_MUL,   G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd4:  w = uw_mk(OP_MUL,   G_P, O_E, 1'b1, 1'b1, 1'b0, J_NEXT, PC_WAIT);
			5'd5:  w = uw_mk(OP_MUL,   G_I, O_S, 1'b0, 1'b1, 1'b1, J_NEXT, PC_WAIT);
			5'd6:  w = uw_mk(OP_MUL,   G_I, O_S, 1'b1, 1'b1, 1'b0, J_NEXT, PC_WAIT);
			5'd7:  w = uw_mk(OP_MUL,   G_D, O_D, 1'b0, 1'b1, 1'b1, J_NEXT, PC_WAIT);
			5'd8:  w = uw_mk(OP_MUL,   G_D, O_D, 1'b1, 1'b1, 1'b0, J_NEXT, PC_WAIT);
			5'd9:  w = uw_mk(OP_ACC,   G_P, O_E, 1'b0, 1'b1, 1'b1, J_NEXT, PC_WAIT);
			5'd10: w = uw_mk(OP_ABS,   G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd11: w = uw_mk(OP_DUTY,  G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd12: w = uw_mk(OP_CMUL,  G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd13: w = uw_mk(OP_RMUL,  G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd14: w = uw_mk(OP_SCALE, G_P, O_E, 1'b0, 1'b0, 1'b0, J_NEXT, PC_WAIT);
			5'd15: w = uw_mk(OP_WR,    G_P, O_E, 1'b0, 1'b0, 1'b0, J_OUT,  PC_WAIT);
			5'd16: w = uw_mk(OP_CLR,   G_P, O_E, 1'b0, 1'b0, 1'b0, J_GOTO, PC_WR);
			default: w = uw_mk(OP_WAIT, G_P, O_E, 1'b0, 1'b0, 1'b0, J_GOTO, PC_WAIT);
		endcase
		return w;
	endfunction

endpackage

@@ src/pidpwm_seq.sv @@
// microprogram sequencer: step counter, control store and jump logic
module pidpwm_seq import pidpwm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_acc,
	input  logic     out_free,
	input  dp_stat_t stat,
	output uword_t   uw
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_inc;
	logic [PC_W-1:0] pc_nxt;

	assign uw     = ucode(pc_q);
	assign pc_inc = pc_q + 5'd1;

	always_comb begin
		case (uw.jcond)
			J_NEXT:  pc_nxt = pc_inc;
			J_IN:    pc_nxt = in_acc ? pc_inc : pc_q;
			J_ACT:   pc_nxt = stat.action ? uw.jtgt : pc_inc;
			J_BAND:  pc_nxt = stat.band ? uw.jtgt : pc_inc;
			J_GOTO:  pc_nxt = uw.jtgt;
			J_OUT:   pc_nxt = out_free ? uw.jtgt : pc_q;
			default: pc_nxt = PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_WAIT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule

@@ src/pidpwm_dp.sv @@
// controller datapath: error, integral, shared multiply-accumulate, duty and compare
module pidpwm_dp import pidpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  uword_t             uw,
	input  logic               in_acc,
	input  logic               in_action,
	input  logic signed [31:0] in_pos,
	input  cfg_t               cfg,
	output dp_stat_t           stat,
	output logic [15:0]        cmp,
	output logic [6:0]         duty,
	output logic               done
);

	logic                     action_q;
	logic signed [31:0]       pos_q;
	logic signed [32:0]       e_q;
	logic signed [33:0]       d_q;
	logic signed [23:0]       error_sum_q;
	logic signed [32:0]       last_error_q;
	logic signed [51:0]       prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [MAG_W-1:0]         mag_q;
	logic [22:0]              scaled_q;
	logic [46:0]              rec_q;
	logic [15:0]              cmp_q;
	logic [6:0]               duty_q;
	logic                     done_q;

	logic signed [32:0]       e_new;
	logic                     band;
	logic signed [33:0]       sum_raw;
	logic signed [23:0]       sum_clamp;
	logic signed [33:0]       d_new;
	logic signed [35:0]       opnd;
	logic signed [18:0]       chunk;
	logic [31:0]              gain;
	logic signed [51:0]       mul_res;
	logic signed [ACC_W-1:0]  prod_x;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_neg;
	logic [15:0]              q_sat;
	logic [6:0]               duty_hi;
	logic [6:0]               duty_new;
	logic [23:0]              scaled_full;
	logic [16:0]              quot;

	assign e_new = {cfg.target[31], cfg.target} - {pos_q[31], pos_q};
	assign band  = (e_q >= -DEADBAND) && (e_q <= DEADBAND);

	// integral with clamp
	assign sum_raw = 34'(error_sum_q) + 34'(e_q);
	always_comb begin
		if (sum_raw > SUM_LIMIT) begin
			sum_clamp = 24'(SUM_LIMIT);
		end else if (sum_raw < -SUM_LIMIT) begin
			sum_clamp = 24'(-SUM_LIMIT);
		end else begin
			sum_clamp = 24'(sum_raw);
		end
	end

	assign d_new = 34'(e_q) - 34'(last_error_q);

	// one 33x19 signed multiply per step, operand split into 18-bit halves
	always_comb begin
		case (uw.osel)
			O_E:     opnd = 36'(e_q);
			O_S:     opnd = 36'(error_sum_q);
			O_D:     opnd = 36'(d_q);
			default: opnd = '0;
		endcase
		case (uw.gsel)
			G_P:     gain = cfg.gain_p;
			G_I:     gain = cfg.gain_i;
			G_D:     gain = cfg.gain_d;
			default: gain = '0;
		endcase
		chunk = uw.hi ? {opnd[35], opnd[35:18]} : {1'b0, opnd[17:0]};
	end

	assign mul_res = $signed({1'b0, gain}) * chunk;
	assign prod_x  = ACC_W'(prod_q);
	assign addend  = uw.acc_hi ? (prod_x <<< 18) : prod_x;
	assign acc_neg = -acc_q;

	// magnitude to duty: saturate, ceiling then floor
	assign q_sat    = (|mag_q[MAG_W-1:32]) ? CMP_MAX : mag_q[31:16];
	assign duty_hi  = (q_sat > {9'd0, cfg.ceil_pct}) ? cfg.ceil_pct : q_sat[6:0];
	assign duty_new = (duty_hi < cfg.floor_pct) ? cfg.floor_pct : duty_hi;

	assign scaled_full = ({1'b0, cfg.period} + 17'd1) * duty_q;
	assign quot        = rec_q[46:RECIP_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else begin
			case (uw.op)
				OP_BAND: begin
					if (!band) begin
						error_sum_q  <= sum_clamp;
						last_error_q <= e_q;
					end
				end
				OP_CLR: begin
					error_sum_q  <= '0;
					last_error_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= in_action;
			pos_q    <= in_pos;
		end
		case (uw.op)
			OP_ERR: e_q <= e_new;
			OP_BAND: begin
				done_q <= band;
				cmp_q  <= '0;
				duty_q <= '0;
				acc_q  <= '0;
				d_q    <= d_new;
			end
			OP_MUL: begin
				prod_q <= mul_res;
				if (uw.acc_en) begin
					acc_q <= acc_q + addend;
				end
			end
			OP_ACC: acc_q <= acc_q + addend;
			OP_ABS: mag_q <= acc_q[ACC_W-1] ? MAG_W'(acc_neg) : MAG_W'(acc_q);
			OP_DUTY: duty_q <= duty_new;
			OP_CMUL: scaled_q <= scaled_full[22:0];
			OP_RMUL: rec_q <= scaled_q * RECIP_100;
			OP_SCALE: cmp_q <= quot[16] ? CMP_MAX : quot[15:0];
			OP_CLR: begin
				done_q <= 1'b0;
				cmp_q  <= '0;
				duty_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.action = action_q;
	assign stat.band   = band;
	assign cmp         = cmp_q;
	assign duty        = duty_q;
	assign done        = done_q;

endmodule

@@ src/pid_position_to_pwm.sv @@
// top level: position controller turning an encoder count into a pwm compare word
// a tick runs error, deadband, multiply, accumulate, magnitude, duty, scale and write steps
// a deadband hit jumps to write, a clear first clears; a held result stalls the next
// the microprogram drives one shared 33x19 multiplier over six passes
// the next word is taken once a result reaches the output register, where it waits
// reset (arst_n low, asynchronous): settings to defaults, integral and last error zeroed
module pid_position_to_pwm import pidpwm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic signed [31:0] measured_position,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        compare_value,
	output logic [6:0]         duty_percent,
	output logic               done_res,
	// configuration writes
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	cfg_t        cfg_q;
	uword_t      uw;
	dp_stat_t    stat;
	logic        in_acc;
	logic        out_free;
	logic        out_load;
	logic [15:0] dp_cmp;
	logic [6:0]  dp_duty;
	logic        dp_done;
	logic        out_valid_q;
	logic [15:0] cmp_q;
	logic [6:0]  duty_q;
	logic        done_q;

	// the sequencer sits in its wait step between words
	assign in_ready = (uw.op == OP_WAIT);
	assign in_acc   = in_valid && in_ready;

	// output register frees when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (uw.op == OP_WR) && out_free;

	// configuration registers, to be written only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target    <= '0;
			cfg_q.gain_p    <= '0;
			cfg_q.gain_i    <= '0;
			cfg_q.gain_d    <= '0;
			cfg_q.floor_pct <= 7'd0;
			cfg_q.ceil_pct  <= 7'd100;
			cfg_q.period    <= 16'd999;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET: cfg_q.target    <= cfg_data;
				REG_GAIN_P: cfg_q.gain_p    <= cfg_data;
				REG_GAIN_I: cfg_q.gain_i    <= cfg_data;
				REG_GAIN_D: cfg_q.gain_d    <= cfg_data;
				REG_FLOOR:  cfg_q.floor_pct <= cfg_data[6:0];
				REG_CEIL:   cfg_q.ceil_pct  <= cfg_data[6:0];
				REG_PERIOD: cfg_q.period    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// microprogram control
	pidpwm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.out_free (out_free),
		.stat     (stat),
		.uw       (uw)
	);

	// arithmetic under microprogram control
	pidpwm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uw        (uw),
		.in_acc    (in_acc),
		.in_action (action),
		.in_pos    (measured_position),
		.cfg       (cfg_q),
		.stat      (stat),
		.cmp       (dp_cmp),
		.duty      (dp_duty),
		.done      (dp_done)
	);

	// output register: valid is control, the fields are payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cmp_q  <= dp_cmp;
			duty_q <= dp_duty;
			done_q <= dp_done;
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_value = cmp_q;
	assign duty_percent  = duty_q;
	assign done_res      = done_q;

	`include "pid_position_to_pwm_assert.svh"

	// a taken word leaves the sequencer busy in the next cycle
	`PIDPWM_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_acc, !in_ready)
	// a deadband result carries no drive
	`PIDPWM_ASSERT_NOW(a_done_no_drive, clk, arst_n, out_valid && done_res,
		compare_value == 16'd0 && duty_percent == 7'd0)
	// zero duty always gives a zero compare word
	`PIDPWM_ASSERT_NOW(a_zero_duty_cmp, clk, arst_n, out_valid && duty_percent == 7'd0,
		compare_value == 16'd0)

endmodule

@@ dv/tb_pid_position_to_pwm.sv @@
// testbench for pid_position_to_pwm: directed table, random moves; typed or predicted results
module tb_pid_position_to_pwm;
	import pidpwm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// deadband and integral clamp of the controller
	localparam int DEAD_ZONE   = 50;
	localparam int INTEG_LIMIT = 5000000;

	// random part: rounds of fresh settings, each with a run of words
	localparam int ROUNDS          = 10;
	localparam int WORDS_PER_ROUND = 48;

	// cycles with no handshake or register write before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	// quiet tail after the last result
	localparam int DRAIN_TAIL  = 40;

	// action field of an input word
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	typedef struct packed {
		logic [15:0] cmp;
		logic [6:0]  duty;
		logic        done;
	} pwm_word_t;

	typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

	// one line of the directed table: a register write or an input word,
	// the latter optionally with its result typed in
	typedef struct packed {
		row_kind_e   kind;
		logic [2:0]  idx;
		logic [31:0] data;
		logic        act;
		logic        typed;
		pwm_word_t   want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_TICK;
	logic signed [31:0] measured_position = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        compare_value;
	logic [6:0]         duty_percent;
	logic               done_res;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = REG_TARGET;
	logic [31:0]        cfg_data = '0;

	// predictor copy of the registers and of the controller state
	cfg_t               regs;
	logic signed [23:0] integ;
	logic signed [32:0] prev_error;

	pwm_word_t   pwm_due [$];
	stim_row_t   directed_rows [$];
	int          fails = 0;
	int unsigned quiet_cycles = 0;
	int unsigned ready_hold = 0;
	bit          calm = 1'b0;

	pid_position_to_pwm dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.measured_position (measured_position),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.compare_value     (compare_value),
		.duty_percent      (duty_percent),
		.done_res          (done_res),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #5 clk = ~clk;

	// idle length: mostly none, often a few cycles, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// gains: zero, full scale, anything, or the small values that keep the duty varied
	function automatic logic [31:0] pick_gain();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 2)
			return '0;
		if (r == 2)
			return 32'hFFFF_FFFF;
		if (r < 5)
			return $urandom;
		return $urandom_range(0, 32'h8000);
	endfunction

	// one control step on the predictor, updating its state like the block does
	function automatic pwm_word_t pwm_from_position(input logic act, input logic [31:0] pos);
		pwm_word_t          res;
		logic signed [32:0] e;
		logic signed [33:0] s;
		logic signed [33:0] d;
		logic signed [71:0] gpw, giw, gdw, ew, sw, dw, u, mag;
		logic [15:0]        q;
		logic [15:0]        level;
		logic [31:0]        scaled;
		res = '0;
		if (act == ACT_CLEAR) begin
			integ = '0;
			prev_error = '0;
			return res;
		end
		e = {regs.target[31], regs.target} - {pos[31], pos};
		// inside the deadband: done, motor off, state untouched
		if (e >= -DEAD_ZONE && e <= DEAD_ZONE) begin
			res.done = 1'b1;
			return res;
		end
		s = {{10{integ[23]}}, integ} + {e[32], e};
		if (s > INTEG_LIMIT)
			s = INTEG_LIMIT;
		else if (s < -INTEG_LIMIT)
			s = -INTEG_LIMIT;
		integ = s[23:0];
		d = {e[32], e} - {prev_error[32], prev_error};
		prev_error = e;
		// exact sum of the three q16.16 terms, at most 69 bits
		gpw = {40'd0, regs.gain_p};
		giw = {40'd0, regs.gain_i};
		gdw = {40'd0, regs.gain_d};
		ew = e;
		sw = integ;
		dw = d;
		u = gpw * ew + giw * sw + gdw * dw;
		mag = u[71] ? -u : u;
		// integer part of the magnitude, saturated to 16 bits
		if (mag[71:32] != '0)
			q = 16'hFFFF;
		else
			q = mag[31:16];
		// ceiling first, then floor, so a floor above the ceiling wins
		level = q;
		if (level > 16'(regs.ceil_pct))
			level = 16'(regs.ceil_pct);
		if (level < 16'(regs.floor_pct))
			level = 16'(regs.floor_pct);
		scaled = (32'(regs.period) + 32'd1) * 32'(level) / 32'd100;
		res.cmp = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
		res.duty = level[6:0];
		return res;
	endfunction

	function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [31:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = val;
		return r;
	endfunction

	function automatic stim_row_t word_row(input logic act, input logic [31:0] pos);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.act = act;
		r.data = pos;
		return r;
	endfunction

	function automatic stim_row_t fixed_row(input logic act, input logic [31:0] pos,
			input logic [15:0] cmp, input logic [6:0] duty, input logic done);
		stim_row_t r;
		r = word_row(act, pos);
		r.typed = 1'b1;
		r.want.cmp = cmp;
		r.want.duty = duty;
		r.want.done = done;
		return r;
	endfunction

	// offer one input word and hold it until taken; the expectation is queued at acceptance
	task automatic offer_word(input logic act, input logic [31:0] pos, input logic typed,
			input pwm_word_t want);
		int unsigned gap;
		pwm_word_t   predicted;
		cfg_we <= 1'b0;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		measured_position <= pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = pwm_from_position(act, pos);
		pwm_due.push_back(typed ? want : predicted);
	endtask

	// stop offering and wait until every result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pwm_due.size() != 0) @(posedge clk);
	endtask

	// one register write, taken at the next edge
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TARGET: regs.target = val;
			REG_GAIN_P: regs.gain_p = val;
			REG_GAIN_I: regs.gain_i = val;
			REG_GAIN_D: regs.gain_d = val;
			REG_FLOOR:  regs.floor_pct = val[6:0];
			REG_CEIL:   regs.ceil_pct = val[6:0];
			REG_PERIOD: regs.period = val[15:0];
			default: ;
		endcase
	endtask

	// receiver: random stalls, held for random stretches, always ready in calm rounds
	always @(posedge clk) begin
		if (ready_hold != 0)
			ready_hold <= ready_hold - 1;
		else begin
			out_ready <= calm ? 1'b1 : ($urandom_range(0, 2) != 0);
			ready_hold <= pick_gap();
		end
	end

	// result checker: each taken word against the oldest expectation
	always @(posedge clk) begin
		pwm_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pwm_due.size() == 0) begin
				$error("unexpected result word: compare_value %0d duty_percent %0d done_res %0d",
					compare_value, duty_percent, done_res);
				fails++;
			end else begin
				want = pwm_due.pop_front();
				if (compare_value !== want.cmp) begin
					$error("compare_value: expected %0d, got %0d", want.cmp, compare_value);
					fails++;
				end
				if (duty_percent !== want.duty) begin
					$error("duty_percent: expected %0d, got %0d", want.duty, duty_percent);
					fails++;
				end
				if (done_res !== want.done) begin
					$error("done_res: expected %0d, got %0d", want.done, done_res);
					fails++;
				end
			end
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$error("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("tb_pid_position_to_pwm: done, errors");
			$finish;
		end
	end

	initial begin
		int          travel;
		int unsigned r;
		logic [31:0] pos;

		// predictor starts from the reset values of the block
		regs.target = '0;
		regs.gain_p = '0;
		regs.gain_i = '0;
		regs.gain_d = '0;
		regs.floor_pct = 7'd0;
		regs.ceil_pct = 7'd100;
		regs.period = 16'd999;
		integ = '0;
		prev_error = '0;
		travel = 0;

		directed_rows = '{
			// reset settings, zero gains: deadband edges and position extremes
			fixed_row(ACT_TICK, 32'd0, 16'd0, 7'd0, 1'b1),
			fixed_row(ACT_TICK, 32'd50, 16'd0, 7'd0, 1'b1),
			fixed_row(ACT_TICK, -32'sd50, 16'd0, 7'd0, 1'b1),
			fixed_row(ACT_TICK, 32'd51, 16'd0, 7'd0, 1'b0),
			fixed_row(ACT_TICK, 32'h7FFF_FFFF, 16'd0, 7'd0, 1'b0),
			fixed_row(ACT_TICK, 32'h8000_0000, 16'd0, 7'd0, 1'b0),
			// clear ignores the position
			fixed_row(ACT_CLEAR, 32'hFFFF_FFFF, 16'd0, 7'd0, 1'b0),
			// unity proportional gain: duty follows the error, capped at the ceiling
			reg_row(REG_GAIN_P, 32'h0001_0000),
			reg_row(REG_TARGET, 32'd1000),
			fixed_row(ACT_TICK, 32'd940, 16'd600, 7'd60, 1'b0),
			fixed_row(ACT_TICK, 32'd0, 16'd1000, 7'd100, 1'b0),
			fixed_row(ACT_TICK, 32'd2000, 16'd1000, 7'd100, 1'b0),
			// full scale gains and period: output and compare both saturate
			reg_row(REG_GAIN_P, 32'hFFFF_FFFF),
			reg_row(REG_GAIN_I, 32'hFFFF_FFFF),
			reg_row(REG_GAIN_D, 32'hFFFF_FFFF),
			reg_row(REG_PERIOD, 32'd65535),
			reg_row(REG_TARGET, 32'h8000_0000),
			fixed_row(ACT_TICK, 32'h7FFF_FFFF, 16'hFFFF, 7'd100, 1'b0),
			fixed_row(ACT_TICK, 32'h8000_0000, 16'd0, 7'd0, 1'b1),
			// floor above ceiling: the floor wins, beyond 100 percent
			reg_row(REG_PERIOD, 32'd99),
			reg_row(REG_FLOOR, 32'd127),
			reg_row(REG_CEIL, 32'd0),
			fixed_row(ACT_TICK, 32'd0, 16'd127, 7'd127, 1'b0),
			fixed_row(ACT_TICK, 32'hFFFF_FFFF, 16'd127, 7'd127, 1'b0),
			fixed_row(ACT_CLEAR, 32'd0, 16'd0, 7'd0, 1'b0),
			// mixed gains, zero period: integral runs into its clamp and back
			reg_row(REG_FLOOR, 32'd0),
			reg_row(REG_CEIL, 32'd100),
			reg_row(REG_PERIOD, 32'd0),
			reg_row(REG_TARGET, 32'd0),
			reg_row(REG_GAIN_P, 32'h0000_8000),
			reg_row(REG_GAIN_I, 32'h0000_0100),
			reg_row(REG_GAIN_D, 32'h0002_0000),
			word_row(ACT_TICK, -32'sd200),
			word_row(ACT_TICK, -32'sd400),
			word_row(ACT_TICK, 32'd3000000),
			word_row(ACT_TICK, 32'd3000000),
			word_row(ACT_TICK, -32'sd4000000),
			word_row(ACT_TICK, 32'd20),
			word_row(ACT_TICK, -32'sd7000000),
			word_row(ACT_CLEAR, 32'h5A5A_5A5A),
			word_row(ACT_TICK, 32'd500)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else
				offer_word(directed_rows[i].act, directed_rows[i].data,
					directed_rows[i].typed, directed_rows[i].want);
		end

		for (int round = 0; round < ROUNDS; round++) begin
			settle();
			// every third round runs without idling on either side
			calm = (round % 3 == 2);
			r = $urandom_range(0, 5);
			write_reg(REG_TARGET, (r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 :
				(r == 2) ? $urandom : 32'($urandom_range(0, 20000)) - 32'd10000);
			write_reg(REG_GAIN_P, pick_gain());
			write_reg(REG_GAIN_I, pick_gain());
			write_reg(REG_GAIN_D, pick_gain());
			write_reg(REG_FLOOR, ($urandom_range(0, 4) == 0) ?
				$urandom_range(0, 127) : $urandom_range(0, 30));
			write_reg(REG_CEIL, ($urandom_range(0, 4) == 0) ?
				$urandom_range(0, 127) : $urandom_range(40, 100));
			r = $urandom_range(0, 4);
			write_reg(REG_PERIOD, (r == 0) ? 32'd0 : (r == 1) ? 32'd65535 :
				(r == 2) ? 32'd999 : $urandom_range(0, 65535));

			for (int n = 0; n < WORDS_PER_ROUND; n++) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					offer_word(ACT_CLEAR, $urandom, 1'b0, '0);
				else if (r < 14)
					// noise: any position at all
					offer_word(ACT_TICK, $urandom, 1'b0, '0);
				else if (r < 24) begin
					// around the deadband edge
					pos = regs.target - 32'(int'($urandom_range(0, 104)) - 52);
					offer_word(ACT_TICK, pos, 1'b0, '0);
				end else begin
					// a move: error shrinks towards the target, now and then overshooting
					if (travel == 0)
						travel = (($urandom_range(0, 1) == 1) ? 1 : -1) *
							int'($urandom_range(51, ($urandom_range(0, 3) == 0) ? 16000000 : 5000));
					pos = regs.target - 32'(travel);
					offer_word(ACT_TICK, pos, 1'b0, '0);
					if (travel >= -DEAD_ZONE && travel <= DEAD_ZONE)
						travel = 0;
					else if ($urandom_range(0, 9) == 0)
						travel = -travel / 2;
					else
						travel = travel - travel / 4;
				end
			end
		end

		settle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (fails == 0)
			$display("tb_pid_position_to_pwm: done, clean");
		else
			$display("tb_pid_position_to_pwm: done, errors");
		$finish;
	end

endmodule
